>>> design/trwu_pkg.sv
package trwu_pkg;

    localparam int TIME_BINS_DEF = 128;
    localparam int SUM_WORDS     = 112;
    localparam int FLAG_GROUPS   = 10;
    localparam int FLAG_X        = 7;
    localparam int FLAG_Z_MAX    = 12;
    localparam int SUM_Z         = 14;
    localparam int LAST_POS      = 127;
    localparam int FLAG_POS_LO   = 2;
    localparam int FLAG_POS_HI   = 11;
    localparam int SUM_POS_LO    = 16;
    localparam int SUM_BUNCH_LEN = 16 + SUM_WORDS;

    typedef enum logic [1:0] {
        OP_WORD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic {
        SW_IDLE,
        SW_RUN
    } sweep_state_t;

    // write beat into either store; bin/group/sum_slot are mapped to addresses in the store
    typedef struct packed {
        logic       flag_we;
        logic       sum_we;
        logic [6:0] bin;
        logic [3:0] group;
        logic [6:0] sum_slot;
        logic [9:0] data;
    } wr_req_t;

    typedef struct packed {
        logic       flag_en;
        logic       sum_en;
        logic [6:0] bin;
        logic [3:0] group;
        logic [6:0] sum_slot;
    } rd_req_t;

    // idx / 10 for idx below 128, by reciprocal multiply
    function automatic logic [3:0] flag_group(input logic [6:0] idx);
        logic [14:0] prod;
        prod = 15'(idx) * 15'(205);
        return prod[14:11];
    endfunction

    function automatic logic [3:0] flag_bit_sel(input logic [6:0] idx);
        logic [6:0] base;
        base = 7'(flag_group(idx)) * 7'(FLAG_GROUPS);
        return 4'(idx - base);
    endfunction

endpackage

>>> design/trwu_cmd_if.sv
interface trwu_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [9:0] raw_word;
    logic       first_word;
    logic [6:0] time_bin;
    logic [9:0] bunch_length;
    logic [2:0] read_x;
    logic [3:0] read_z;

    modport source (
        output valid, operation, raw_word, first_word, time_bin, bunch_length,
               read_x, read_z,
        input  ready
    );
    modport sink (
        input  valid, operation, raw_word, first_word, time_bin, bunch_length,
               read_x, read_z,
        output ready
    );
endinterface

>>> design/trwu_rsp_if.sv
interface trwu_rsp_if;
    logic       valid;
    logic       ready;
    logic       flag_bit;
    logic [9:0] window_sum;
    logic       bin_active;
    logic       any_active;

    modport source (
        output valid, flag_bit, window_sum, bin_active, any_active,
        input  ready
    );
    modport sink (
        input  valid, flag_bit, window_sum, bin_active, any_active,
        output ready
    );
endinterface

>>> design/trwu_word_track.sv
module trwu_word_track (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat,
    input  logic [9:0]        raw_word,
    input  logic              first_word,
    input  logic [6:0]        time_bin,
    input  logic [9:0]        bunch_length,
    input  logic              bin_ok,
    output trwu_pkg::wr_req_t wr
);

    logic [6:0] pos_reg, pos_next;
    logic [6:0] hbin_reg, hbin_next;
    logic       sums_reg, sums_next;
    logic       idle_reg, idle_next;
    logic       hbin_valid_reg, hbin_valid_next;

    logic [6:0] pos_e;
    logic [6:0] bin_e;
    logic       sums_e;
    logic       idle_e;
    logic       hbin_ok;

    // first word overrides the held bunch state for its own beat
    assign pos_e  = first_word ? 7'd0 : pos_reg;
    assign bin_e  = first_word ? time_bin : hbin_reg;
    assign sums_e = first_word ? (bunch_length == 10'(trwu_pkg::SUM_BUNCH_LEN)) : sums_reg;
    assign idle_e = first_word ? 1'b0 : idle_reg;
    // bin_ok checks the incoming bin; the held one was checked when it was latched
    assign hbin_ok = first_word ? bin_ok : hbin_valid_reg;

    always_comb
    begin
        pos_next        = pos_reg;
        hbin_next       = hbin_reg;
        sums_next       = sums_reg;
        idle_next       = idle_reg;
        hbin_valid_next = hbin_valid_reg;
        if (beat)
        begin
            hbin_next       = bin_e;
            sums_next       = sums_e;
            hbin_valid_next = hbin_ok;
            idle_next       = idle_e;
            pos_next        = pos_e;
            if (!idle_e)
            begin
                if (pos_e == 7'(trwu_pkg::LAST_POS))
                    idle_next = 1'b1;
                else
                    pos_next = pos_e + 7'd1;
            end
        end
    end

    always_comb
    begin
        wr.bin      = bin_e;
        wr.data     = raw_word;
        // word p carries flag indices 10*(11-p) .. 10*(11-p)+9
        wr.group    = 4'(7'(trwu_pkg::FLAG_POS_HI) - pos_e);
        // sum slot = 111 - (p - 16)
        wr.sum_slot = 7'(trwu_pkg::LAST_POS) - pos_e;
        wr.flag_we  = beat && !idle_e && hbin_ok
                      && pos_e >= 7'(trwu_pkg::FLAG_POS_LO)
                      && pos_e <= 7'(trwu_pkg::FLAG_POS_HI);
        wr.sum_we   = beat && !idle_e && hbin_ok && sums_e
                      && pos_e >= 7'(trwu_pkg::SUM_POS_LO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 7'd0;
            hbin_reg       <= 7'd0;
            sums_reg       <= 1'b0;
            idle_reg       <= 1'b1;
            hbin_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            hbin_reg       <= hbin_next;
            sums_reg       <= sums_next;
            idle_reg       <= idle_next;
            hbin_valid_reg <= hbin_valid_next;
        end
    end

endmodule

>>> design/trwu_sweep.sv
module trwu_sweep #(
    parameter int TIME_BINS = trwu_pkg::TIME_BINS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TIME_BINS-1:0] active_bins,
    output logic                 busy,
    output logic                 done,
    output trwu_pkg::wr_req_t    wr
);

    localparam int BinW = (TIME_BINS > 1) ? $clog2(TIME_BINS) : 1;

    trwu_pkg::sweep_state_t state_reg, state_next;
    logic [BinW-1:0] bin_reg, bin_next;
    logic [6:0]      cell_reg, cell_next;
    logic            all_reg, all_next;

    logic hit;
    logic bin_done;
    logic last_step;

    // after reset every bin is cleared, after a clear only the active ones
    assign hit       = all_reg || active_bins[bin_reg];
    assign bin_done  = !hit || (cell_reg == 7'(trwu_pkg::SUM_WORDS - 1));
    assign last_step = bin_done && (bin_reg == BinW'(TIME_BINS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trwu_pkg::SW_IDLE: if (start) state_next = trwu_pkg::SW_RUN;
            trwu_pkg::SW_RUN:  if (last_step) state_next = trwu_pkg::SW_IDLE;
            default:           state_next = trwu_pkg::SW_IDLE;
        endcase
    end

    always_comb
    begin
        bin_next  = bin_reg;
        cell_next = cell_reg;
        all_next  = all_reg;
        if (start)
        begin
            bin_next  = '0;
            cell_next = 7'd0;
            all_next  = 1'b0;
        end
        else if (state_reg == trwu_pkg::SW_RUN)
        begin
            if (last_step)
            begin
                bin_next  = '0;
                cell_next = 7'd0;
                all_next  = 1'b0;
            end
            else if (bin_done)
            begin
                bin_next  = bin_reg + BinW'(1);
                cell_next = 7'd0;
            end
            else
                cell_next = cell_reg + 7'd1;
        end
    end

    always_comb
    begin
        busy        = (state_reg == trwu_pkg::SW_RUN);
        done        = busy && last_step;
        wr.bin      = 7'(bin_reg);
        wr.group    = cell_reg[3:0];
        wr.sum_slot = cell_reg;
        wr.data     = 10'd0;
        wr.sum_we   = busy && hit;
        wr.flag_we  = busy && hit && (cell_reg < 7'(trwu_pkg::FLAG_GROUPS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trwu_pkg::SW_RUN;
            bin_reg   <= '0;
            cell_reg  <= 7'd0;
            all_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
            cell_reg  <= cell_next;
            all_reg   <= all_next;
        end
    end

endmodule

>>> design/trwu_store.sv
module trwu_store #(
    parameter int TIME_BINS = trwu_pkg::TIME_BINS_DEF
) (
    input  logic              clk,
    input  trwu_pkg::wr_req_t wr,
    input  trwu_pkg::rd_req_t rd,
    output logic [9:0]        flag_rdata,
    output logic [9:0]        sum_rdata
);

    localparam int FlagDepth = TIME_BINS * trwu_pkg::FLAG_GROUPS;
    localparam int SumDepth  = TIME_BINS * trwu_pkg::SUM_WORDS;
    localparam int FlagAw    = $clog2(FlagDepth);
    localparam int SumAw     = $clog2(SumDepth);

    logic [9:0] flag_mem [FlagDepth];
    logic [9:0] sum_mem  [SumDepth];

    logic [9:0] flag_rdata_reg;
    logic [9:0] sum_rdata_reg;

    logic [FlagAw-1:0] flag_waddr, flag_raddr;
    logic [SumAw-1:0]  sum_waddr, sum_raddr;

    assign flag_waddr = FlagAw'(FlagAw'(wr.bin) * FlagAw'(trwu_pkg::FLAG_GROUPS)
                        + FlagAw'(wr.group));
    assign flag_raddr = FlagAw'(FlagAw'(rd.bin) * FlagAw'(trwu_pkg::FLAG_GROUPS)
                        + FlagAw'(rd.group));
    assign sum_waddr  = SumAw'(SumAw'(wr.bin) * SumAw'(trwu_pkg::SUM_WORDS)
                        + SumAw'(wr.sum_slot));
    assign sum_raddr  = SumAw'(SumAw'(rd.bin) * SumAw'(trwu_pkg::SUM_WORDS)
                        + SumAw'(rd.sum_slot));

    always_ff @(posedge clk)
    begin
        if (wr.flag_we)
            flag_mem[flag_waddr] <= wr.data;
        if (rd.flag_en)
            flag_rdata_reg <= flag_mem[flag_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.sum_we)
            sum_mem[sum_waddr] <= wr.data;
        if (rd.sum_en)
            sum_rdata_reg <= sum_mem[sum_raddr];
    end

    assign flag_rdata = flag_rdata_reg;
    assign sum_rdata  = sum_rdata_reg;

endmodule

>>> design/trigger_region_word_unpacker_unit.sv
// Unpacks bunches of 10-bit readout words into per-time-bin flag and sum memories.
// Raw words and reads are taken one per cycle unless held off; a read's result passes
// through a pending stage and an output register, and a stalled result holds off
// further beats only once both of those are full. The flag memory holds ten flags
// per word, so each flag word is written whole and never read back for update.
// A clear walks the bins through the sum memory's single write port, writing all 112
// sum words of each active bin and skipping each inactive bin; no beat is taken
// meanwhile. After reset the same sequencer zeroes both memories in every bin before
// the first beat is accepted.
module trigger_region_word_unpacker_unit #(
    parameter int TIME_BINS = trwu_pkg::TIME_BINS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    trwu_cmd_if.sink          cmd,
    trwu_rsp_if.source        rsp
);

    localparam int BinW = (TIME_BINS > 1) ? $clog2(TIME_BINS) : 1;

    logic [TIME_BINS-1:0] active_reg, active_next;
    logic                 any_reg, any_next;

    logic        accept;
    logic        bin_ok;
    trwu_pkg::op_t op;
    logic        word_beat;
    logic        clear_start;
    logic        read_issue;

    logic        sweep_busy;
    logic        sweep_done;
    trwu_pkg::wr_req_t word_wr, sweep_wr, mem_wr;
    trwu_pkg::rd_req_t mem_rd;
    logic [9:0]  flag_rdata, sum_rdata;

    logic [6:0]  flag_idx;
    logic        flag_ok, sum_ok;

    logic        pend_reg, pend_next;
    logic        pflag_ok_reg, psum_ok_reg, pact_reg, pany_reg;
    logic [3:0]  pbit_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_flag_reg, out_act_reg, out_any_reg;
    logic [9:0]  out_sum_reg;
    logic        move;

    assign op      = trwu_pkg::op_t'(cmd.operation);
    assign move    = pend_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !sweep_busy && !(pend_reg && !move);
    assign accept  = cmd.valid && cmd.ready;
    assign bin_ok  = (8'(cmd.time_bin) < 8'(TIME_BINS));

    always_comb
    begin
        word_beat   = 1'b0;
        clear_start = 1'b0;
        read_issue  = 1'b0;
        unique case (op)
            trwu_pkg::OP_WORD:  word_beat   = accept;
            trwu_pkg::OP_CLEAR: clear_start = accept && any_reg;
            trwu_pkg::OP_READ:  read_issue  = accept;
            trwu_pkg::OP_NOP:   ;
        endcase
    end

    trwu_word_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (word_beat),
        .raw_word     (cmd.raw_word),
        .first_word   (cmd.first_word),
        .time_bin     (cmd.time_bin),
        .bunch_length (cmd.bunch_length),
        .bin_ok       (bin_ok),
        .wr           (word_wr)
    );

    trwu_sweep #(.TIME_BINS(TIME_BINS)) u_sweep (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (clear_start),
        .active_bins (active_reg),
        .busy        (sweep_busy),
        .done        (sweep_done),
        .wr          (sweep_wr)
    );

    assign mem_wr = sweep_busy ? sweep_wr : word_wr;

    // flag index rz*7+rx, split into word and bit
    assign flag_idx = 7'(cmd.read_z) * 7'(trwu_pkg::FLAG_X) + 7'(cmd.read_x);
    assign flag_ok  = bin_ok && (cmd.read_x < 3'(trwu_pkg::FLAG_X))
                      && (cmd.read_z <= 4'(trwu_pkg::FLAG_Z_MAX));
    assign sum_ok   = bin_ok && (cmd.read_z < 4'(trwu_pkg::SUM_Z));

    always_comb
    begin
        mem_rd.flag_en  = read_issue && flag_ok;
        mem_rd.sum_en   = read_issue && sum_ok;
        mem_rd.bin      = cmd.time_bin;
        mem_rd.group    = trwu_pkg::flag_group(flag_idx);
        mem_rd.sum_slot = {cmd.read_z, cmd.read_x};
    end

    trwu_store #(.TIME_BINS(TIME_BINS)) u_store (
        .clk        (clk),
        .wr         (mem_wr),
        .rd         (mem_rd),
        .flag_rdata (flag_rdata),
        .sum_rdata  (sum_rdata)
    );

    always_comb
    begin
        active_next = active_reg;
        any_next    = any_reg;
        if (sweep_done)
        begin
            active_next = '0;
            any_next    = 1'b0;
        end
        else if (word_beat && cmd.first_word)
        begin
            any_next = 1'b1;
            if (bin_ok)
                active_next[cmd.time_bin[BinW-1:0]] = 1'b1;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (read_issue)
            pend_next = 1'b1;
        else if (move)
            pend_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            any_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            any_reg       <= any_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_issue)
        begin
            pflag_ok_reg <= flag_ok;
            psum_ok_reg  <= sum_ok;
            pbit_reg     <= trwu_pkg::flag_bit_sel(flag_idx);
            pact_reg     <= bin_ok && active_reg[cmd.time_bin[BinW-1:0]];
            pany_reg     <= any_reg;
        end
        if (move)
        begin
            out_flag_reg <= pflag_ok_reg && flag_rdata[pbit_reg];
            out_sum_reg  <= psum_ok_reg ? sum_rdata : 10'd0;
            out_act_reg  <= pact_reg;
            out_any_reg  <= pany_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.flag_bit   = out_flag_reg;
    assign rsp.window_sum = out_sum_reg;
    assign rsp.bin_active = out_act_reg;
    assign rsp.any_active = out_any_reg;

endmodule

>>> design/trwu_checker.sv
module trwu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] cmd_operation,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_flag_bit,
    input logic [9:0] rsp_window_sum,
    input logic       rsp_bin_active,
    input logic       rsp_any_active
);

    // a stalled result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({rsp_flag_bit, rsp_window_sum, rsp_bin_active, rsp_any_active}))
        else $error("result beat dropped or changed while stalled");

    // an active bin implies the block saw a bunch
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_bin_active |-> rsp_any_active)
        else $error("bin active reported without any activity");

    // a fresh result beat always traces back to an accepted read beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_valid && cmd_ready
            && (cmd_operation == trwu_pkg::OP_READ), 2))
        else $error("result beat without a matching read");

    // results never appear from non-read beats alone
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid && cmd_valid && cmd_ready
            && (cmd_operation != trwu_pkg::OP_READ) |=> ##1 !$rose(rsp_valid))
        else $error("result beat after a non-read beat");

endmodule

bind trigger_region_word_unpacker_unit trwu_checker u_trwu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_operation  (cmd.operation),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_flag_bit   (rsp.flag_bit),
    .rsp_window_sum (rsp.window_sum),
    .rsp_bin_active (rsp.bin_active),
    .rsp_any_active (rsp.any_active)
);

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int FLAG_CELLS  = trwu_pkg::FLAG_X * (trwu_pkg::FLAG_Z_MAX + 1);
    localparam int NBINS       = trwu_pkg::TIME_BINS_DEF;
    localparam int QUIET_LIMIT = 100000;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE   = 6;

    typedef struct packed {
        trwu_pkg::op_t op;
        logic [9:0]    word;
        logic          first;
        logic [6:0]    bin;
        logic [9:0]    len;
        logic [2:0]    x;
        logic [3:0]    z;
    } unpack_cmd_t;

    typedef struct packed {
        logic       flag;
        logic [9:0] sum;
        logic       bin_act;
        logic       any_act;
    } cell_rsp_t;

    // typed-in expectation for a read beat, used instead of the prediction when pinned
    typedef struct packed {
        logic      pinned;
        cell_rsp_t want;
    } pin_t;

    typedef struct {
        unpack_cmd_t cmd;
        int          reps;
        bit          pinned;
        cell_rsp_t   want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    trwu_cmd_if cmd_bus ();
    trwu_rsp_if rsp_bus ();

    trigger_region_word_unpacker_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus.sink),
        .rsp   (rsp_bus.source)
    );

    // unpacker state as the predictor sees it
    logic [FLAG_CELLS-1:0] flag_mem [NBINS];
    logic [9:0]            sum_mem  [NBINS][trwu_pkg::SUM_WORDS];
    logic [NBINS-1:0]      bin_seen;
    logic                  any_seen_q;
    int unsigned           word_pos;
    logic [6:0]            open_bin;
    logic                  want_sums;
    logic                  counter_idle;

    cell_rsp_t   due_cells [$];
    pin_t        pin_q [$];
    dir_row_t    dir_rows [$];
    logic [6:0]  bin_pool [POOL_SIZE];

    int mismatches;
    int quiet_cycles;
    int gap_pct;
    int stall_pct;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Advances the predictor by one accepted beat; returns 1 when a cell read is due.
    function automatic bit unpack_beat(input unpack_cmd_t c, output cell_rsp_t r);
        int idx;
        int k;
        int slot;
        int b;
        int t;
        int j;
        r = '0;
        case (c.op)
            trwu_pkg::OP_WORD:
            begin
                if (c.first)
                begin
                    open_bin     = c.bin;
                    want_sums    = (c.len == 10'(trwu_pkg::SUM_BUNCH_LEN));
                    word_pos     = 0;
                    counter_idle = 1'b0;
                    any_seen_q   = 1'b1;
                    bin_seen[c.bin] = 1'b1;
                end
                if (!counter_idle)
                begin
                    if (word_pos >= trwu_pkg::FLAG_POS_LO && word_pos <= trwu_pkg::FLAG_POS_HI)
                    begin
                        for (b = 0; b < trwu_pkg::FLAG_GROUPS; b++)
                        begin
                            idx = trwu_pkg::FLAG_GROUPS
                                  * (trwu_pkg::FLAG_POS_HI - int'(word_pos)) + b;
                            if (idx < FLAG_CELLS)
                                flag_mem[open_bin][idx] = c.word[b];
                        end
                    end
                    if (want_sums && word_pos >= trwu_pkg::SUM_POS_LO
                        && word_pos <= trwu_pkg::LAST_POS)
                    begin
                        k    = int'(word_pos) - trwu_pkg::SUM_POS_LO;
                        slot = (trwu_pkg::SUM_Z - 1 - k / 8) * 8 + (7 - k % 8);
                        sum_mem[open_bin][slot] = c.word;
                    end
                    if (word_pos >= trwu_pkg::LAST_POS)
                        counter_idle = 1'b1;
                    else
                        word_pos++;
                end
                return 1'b0;
            end
            trwu_pkg::OP_CLEAR:
            begin
                if (any_seen_q)
                begin
                    for (t = 0; t < NBINS; t++)
                    begin
                        if (bin_seen[t])
                        begin
                            flag_mem[t] = '0;
                            for (j = 0; j < trwu_pkg::SUM_WORDS; j++)
                                sum_mem[t][j] = '0;
                        end
                    end
                    bin_seen   = '0;
                    any_seen_q = 1'b0;
                end
                return 1'b0;
            end
            trwu_pkg::OP_READ:
            begin
                if (c.x < trwu_pkg::FLAG_X && c.z <= trwu_pkg::FLAG_Z_MAX)
                    r.flag = flag_mem[c.bin][int'(c.z) * trwu_pkg::FLAG_X + int'(c.x)];
                if (c.z < trwu_pkg::SUM_Z)
                    r.sum = sum_mem[c.bin][int'(c.z) * 8 + int'(c.x)];
                r.bin_act = bin_seen[c.bin];
                r.any_act = any_seen_q;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Accepted beats and results, both sampled at the rising edge.
    always @(posedge clk)
    begin
        unpack_cmd_t seen;
        cell_rsp_t   want;
        cell_rsp_t   got;
        pin_t        pin;
        if (rst_n)
        begin
            quiet_cycles++;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                quiet_cycles = 0;
                seen.op    = trwu_pkg::op_t'(cmd_bus.operation);
                seen.word  = cmd_bus.raw_word;
                seen.first = cmd_bus.first_word;
                seen.bin   = cmd_bus.time_bin;
                seen.len   = cmd_bus.bunch_length;
                seen.x     = cmd_bus.read_x;
                seen.z     = cmd_bus.read_z;
                if (unpack_beat(seen, want))
                begin
                    pin = pin_q.pop_front();
                    if (pin.pinned)
                        want = pin.want;
                    due_cells.push_back(want);
                end
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                quiet_cycles = 0;
                got.flag    = rsp_bus.flag_bit;
                got.sum     = rsp_bus.window_sum;
                got.bin_act = rsp_bus.bin_active;
                got.any_act = rsp_bus.any_active;
                if (due_cells.size() == 0)
                    report_mismatch("result beat with no read due", 1, 0);
                else
                begin
                    want = due_cells.pop_front();
                    if (got.flag != want.flag)
                        report_mismatch("flag_bit", got.flag, want.flag);
                    if (got.sum != want.sum)
                        report_mismatch("window_sum", got.sum, want.sum);
                    if (got.bin_act != want.bin_act)
                        report_mismatch("bin_active", got.bin_act, want.bin_act);
                    if (got.any_act != want.any_act)
                        report_mismatch("any_active", got.any_act, want.any_act);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when asked for.
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic unpack_cmd_t mk_cmd(input trwu_pkg::op_t op, input logic [9:0] word,
                                           input logic first, input logic [6:0] bin,
                                           input logic [9:0] len, input logic [2:0] x,
                                           input logic [3:0] z);
        unpack_cmd_t c;
        c.op    = op;
        c.word  = word;
        c.first = first;
        c.bin   = bin;
        c.len   = len;
        c.x     = x;
        c.z     = z;
        return c;
    endfunction

    function automatic unpack_cmd_t rand_cmd(input trwu_pkg::op_t op);
        return mk_cmd(op, 10'($urandom), 1'($urandom), 7'($urandom), 10'($urandom),
                      3'($urandom), 4'($urandom));
    endfunction

    function automatic logic [6:0] pool_bin();
        if ($urandom_range(99) < 85)
            return bin_pool[$urandom_range(POOL_SIZE - 1)];
        return 7'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic drive_beat(input unpack_cmd_t c, input bit pinned, input cell_rsp_t want);
        pin_t p;
        while (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        if (c.op == trwu_pkg::OP_READ)
        begin
            p.pinned = pinned;
            p.want   = want;
            pin_q.push_back(p);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.operation    <= c.op;
        cmd_bus.raw_word     <= c.word;
        cmd_bus.first_word   <= c.first;
        cmd_bus.time_bin     <= c.bin;
        cmd_bus.bunch_length <= c.len;
        cmd_bus.read_x       <= c.x;
        cmd_bus.read_z       <= c.z;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        @(negedge clk);
    endtask

    task automatic drive_read(input logic [6:0] bin);
        unpack_cmd_t c;
        c     = rand_cmd(trwu_pkg::OP_READ);
        c.bin = bin;
        // z beyond the sum grid now and then
        c.z   = ($urandom_range(99) < 4) ? 4'($urandom_range(15, 14)) : 4'($urandom_range(13));
        drive_beat(c, 1'b0, '0);
    endtask

    // always lets at least one falling edge pass, so valid is never assigned twice at once
    task automatic wait_drained();
        do
            @(negedge clk);
        while (due_cells.size() != 0);
    endtask

    task automatic run_random(input int quota);
        int          done;
        int          pick;
        int          kind;
        int          nwords;
        int          n;
        int          i;
        logic [6:0]  bin;
        logic [9:0]  len;
        unpack_cmd_t c;
        done = 0;
        while (done < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                drive_beat(rand_cmd(trwu_pkg::OP_CLEAR), 1'b0, '0);
                done++;
            end
            else if (pick < 10)
            begin
                // noise: stray words or the unused code
                c = rand_cmd(($urandom_range(2) == 0) ? trwu_pkg::OP_NOP : trwu_pkg::OP_WORD);
                c.first = 1'b0;
                drive_beat(c, 1'b0, '0);
            end
            else if (pick < 30)
            begin
                n = $urandom_range(6, 1);
                for (i = 0; i < n; i++)
                    drive_read(pool_bin());
                done += n;
            end
            else
            begin
                bin  = pool_bin();
                kind = $urandom_range(9);
                len  = 10'(trwu_pkg::SUM_BUNCH_LEN);
                if (kind < 3)
                    nwords = trwu_pkg::LAST_POS + 1 + $urandom_range(4);
                else if (kind < 8)
                begin
                    len    = 10'($urandom);
                    nwords = $urandom_range(30, 3);
                end
                else if (kind == 8)
                    nwords = $urandom_range(trwu_pkg::LAST_POS, 12);
                else
                begin
                    len    = $urandom_range(1) ? 10'(trwu_pkg::SUM_BUNCH_LEN - 1)
                                               : 10'(trwu_pkg::SUM_BUNCH_LEN + 1);
                    nwords = trwu_pkg::LAST_POS + 1;
                end
                for (i = 0; i < nwords; i++)
                begin
                    if ($urandom_range(99) < 8)
                        drive_read($urandom_range(1) ? bin : pool_bin());
                    c       = rand_cmd(trwu_pkg::OP_WORD);
                    c.first = (i == 0);
                    c.bin   = bin;
                    c.len   = len;
                    drive_beat(c, 1'b0, '0);
                end
                done += (nwords > trwu_pkg::LAST_POS + 1) ? trwu_pkg::LAST_POS + 1 : nwords;
            end
        end
    endtask

    initial
    begin
        unpack_cmd_t c;
        int          r;
        int          i;
        int          ph;

        rst_n                = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.operation    = trwu_pkg::OP_NOP;
        cmd_bus.raw_word     = '0;
        cmd_bus.first_word   = 1'b0;
        cmd_bus.time_bin     = '0;
        cmd_bus.bunch_length = '0;
        cmd_bus.read_x       = '0;
        cmd_bus.read_z       = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_left    = 0;
        for (i = 0; i < NBINS; i++)
        begin
            flag_mem[i] = '0;
            for (r = 0; r < trwu_pkg::SUM_WORDS; r++)
                sum_mem[i][r] = '0;
        end
        bin_seen     = '0;
        any_seen_q   = 1'b0;
        word_pos     = 0;
        open_bin     = '0;
        want_sums    = 1'b0;
        counter_idle = 1'b1;

        // fresh out of reset, nothing open, nothing active
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd0, 10'd0,
                                    3'd0, 4'd0), 1, 1'b1, '{1'b0, 10'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd127, 10'd0,
                                    3'd7, 4'd15), 1, 1'b1, '{1'b0, 10'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_NOP, 10'h3ff, 1'b1, 7'd127, 10'h3ff,
                                    3'd7, 4'd15), 1, 1'b0, '0});
        // stray word before any bunch, clear with nothing seen
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_WORD, 10'h3ff, 1'b0, 7'd3, 10'd0,
                                    3'd0, 4'd0), 1, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_CLEAR, 10'd0, 1'b0, 7'd0, 10'd0,
                                    3'd0, 4'd0), 1, 1'b0, '0});
        // full-length bunch of all ones, then words past the last position
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_WORD, 10'h3ff, 1'b1, 7'd127,
                                    10'(trwu_pkg::SUM_BUNCH_LEN), 3'd0, 4'd0),
                             trwu_pkg::LAST_POS + 1, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_WORD, 10'd0, 1'b0, 7'd0, 10'd0,
                                    3'd0, 4'd0), 3, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd127, 10'd0,
                                    3'd0, 4'd0), 1, 1'b1, '{1'b1, 10'h3ff, 1'b1, 1'b1}});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd127, 10'd0,
                                    3'd6, 4'd12), 1, 1'b1, '{1'b1, 10'h3ff, 1'b1, 1'b1}});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd127, 10'd0,
                                    3'd7, 4'd13), 1, 1'b1, '{1'b0, 10'h3ff, 1'b1, 1'b1}});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd127, 10'd0,
                                    3'd3, 4'd14), 1, 1'b1, '{1'b0, 10'd0, 1'b1, 1'b1}});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd0, 10'd0,
                                    3'd0, 4'd0), 1, 1'b1, '{1'b0, 10'd0, 1'b0, 1'b1}});
        // length is not checked; a second first word restarts the count
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_WORD, 10'h155, 1'b1, 7'd0, 10'd0,
                                    3'd0, 4'd0), 14, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_WORD, 10'h2aa, 1'b1, 7'd0, 10'h3ff,
                                    3'd0, 4'd0), 6, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd0, 10'd0,
                                    3'd5, 4'd10), 1, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd0, 10'd0,
                                    3'd2, 4'd12), 1, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_CLEAR, 10'd0, 1'b0, 7'd0, 10'd0,
                                    3'd0, 4'd0), 1, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd127, 10'd0,
                                    3'd0, 4'd0), 1, 1'b1, '{1'b0, 10'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd0, 10'd0,
                                    3'd6, 4'd12), 1, 1'b1, '{1'b0, 10'd0, 1'b0, 1'b0}});
        // clear leaves the open bunch running: its words land in an inactive bin
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_WORD, 10'h3ff, 1'b0, 7'd0, 10'd0,
                                    3'd0, 4'd0), 6, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd0, 10'd0,
                                    3'd0, 4'd0), 1, 1'b0, '0});
        // one word short of a sum bunch: flags only
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_WORD, 10'h3ff, 1'b1, 7'd64,
                                    10'(trwu_pkg::SUM_BUNCH_LEN - 1), 3'd0, 4'd0),
                             20, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd64, 10'd0,
                                    3'd7, 4'd13), 1, 1'b0, '0});
        dir_rows.push_back('{mk_cmd(trwu_pkg::OP_READ, 10'd0, 1'b0, 7'd64, 10'd0,
                                    3'd1, 4'd3), 1, 1'b0, '0});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            for (r = 0; r < dir_rows[i].reps; r++)
            begin
                c = dir_rows[i].cmd;
                if (r > 0)
                    c.first = 1'b0;
                drive_beat(c, dir_rows[i].pinned, dir_rows[i].want);
            end
        end
        cmd_bus.valid <= 1'b0;
        wait_drained();

        // long result hold-off while reads keep coming: input must back up
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 12; i++)
            drive_read(i < 6 ? 7'd127 : 7'd0);
        cmd_bus.valid <= 1'b0;
        wait_drained();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 47;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 47;
                end
                default:
                begin
                    gap_pct   = 24;
                    stall_pct = 24;
                end
            endcase
            for (i = 0; i < POOL_SIZE; i++)
                bin_pool[i] = 7'($urandom);
            run_random(160);
            cmd_bus.valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
